@@ design/cas_pkg.sv @@
// shared constants, types and helper functions for the cave smoothing block
// no dependencies; imported by the interfaces, cas_rsp_buf, the top module and the testbench

package cas_pkg;

   // map size limits
   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 128;

   // configuration port
   localparam int SIZE_W    = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_MAP_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MAP_HEIGHT = CSR_IDX_W'(1);

   // request kinds
   localparam logic REQ_TILE  = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // derived widths
   localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int RING_AW = $clog2(MAX_WIDTH + 4);
   localparam int RING_DEPTH = 1 << RING_AW;

   // reset map size
   localparam logic [WDIM_W-1:0] WIDTH_RESET  = WDIM_W'(64);
   localparam logic [HDIM_W-1:0] HEIGHT_RESET = HDIM_W'(64);

   // wall count at which the tile keeps its own value
   localparam logic [3:0] RULE_LEVEL = 4'd4;

   typedef struct packed {
      logic smoothed_tile;
      logic end_of_map;
   } cas_result_type;

   // zero reads as one, values above the limit read as the limit
   function automatic logic [WDIM_W-1:0] clamp_width(input logic [SIZE_W-1:0] value);
      logic [WDIM_W-1:0] result;
      if (value == '0) begin
         result = WDIM_W'(1);
      end else if (32'(value) > MAX_WIDTH) begin
         result = WDIM_W'(MAX_WIDTH);
      end else begin
         result = WDIM_W'(value);
      end
      return result;
   endfunction

   function automatic logic [HDIM_W-1:0] clamp_height(input logic [SIZE_W-1:0] value);
      logic [HDIM_W-1:0] result;
      if (value == '0) begin
         result = HDIM_W'(1);
      end else if (32'(value) > MAX_HEIGHT) begin
         result = HDIM_W'(MAX_HEIGHT);
      end else begin
         result = HDIM_W'(value);
      end
      return result;
   endfunction

   // 4-5 rule: more than four walls makes a wall, fewer makes floor
   function automatic logic apply_rule(input logic [3:0] walls, input logic centre);
      logic result;
      if (walls > RULE_LEVEL) begin
         result = 1'b1;
      end else if (walls < RULE_LEVEL) begin
         result = 1'b0;
      end else begin
         result = centre;
      end
      return result;
   endfunction

endpackage

@@ design/cas_if.sv @@
// request, response and configuration channels of the cave smoothing block
// depends on cas_pkg for field widths

interface cas_req_if import cas_pkg::*; ();
   logic valid;
   logic ready;
   logic req_type;
   logic in_tile;

   modport source (output valid, output req_type, output in_tile, input ready);
   modport sink   (input valid, input req_type, input in_tile, output ready);
endinterface

interface cas_rsp_if import cas_pkg::*; ();
   logic valid;
   logic ready;
   logic smoothed_tile;
   logic end_of_map;

   modport source (output valid, output smoothed_tile, output end_of_map, input ready);
   modport sink   (input valid, input smoothed_tile, input end_of_map, output ready);
endinterface

interface cas_csr_if import cas_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [SIZE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/cas_ram.sv @@
// generic ram: one write port, two read ports with registered read data
// standalone, no package dependency

module cas_ram #(
   parameter int DATA_W = 1,
   parameter int DEPTH  = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [DATA_W-1:0]        rd_data_a,
   output logic [DATA_W-1:0]        rd_data_b
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   // reads return the contents before a write at the same edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ design/cas_rsp_buf.sv @@
// response output register with a skid entry behind it
// depends on cas_pkg (result struct) and cas_rsp_if

module cas_rsp_buf import cas_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  cas_result_type push_data,
   output logic           can_push,
   cas_rsp_if.source      rsp_chan
);

   logic           out_vld_ff, out_vld_in;
   cas_result_type out_dat_ff, out_dat_in;
   logic           skid_vld_ff, skid_vld_in;
   cas_result_type skid_dat_ff, skid_dat_in;
   logic           out_free;

   // output slot frees when empty or taken this cycle
   assign out_free = !out_vld_ff || rsp_chan.ready;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_dat_in  = out_dat_ff;
      skid_vld_in = skid_vld_ff;
      skid_dat_in = skid_dat_ff;
      if (!out_free) begin
         if (push) begin
            skid_vld_in = 1'b1;
            skid_dat_in = push_data;
         end
      end else if (skid_vld_ff) begin
         out_vld_in  = 1'b1;
         out_dat_in  = skid_dat_ff;
         skid_vld_in = push;
         skid_dat_in = push_data;
      end else begin
         out_vld_in = push;
         out_dat_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_dat_ff  <= out_dat_in;
      skid_dat_ff <= skid_dat_in;
   end

   assign can_push               = !skid_vld_ff;
   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.smoothed_tile = out_dat_ff.smoothed_tile;
   assign rsp_chan.end_of_map    = out_dat_ff.end_of_map;

endmodule

@@ design/cave_automaton_smoothing.sv @@
// cave smoothing, one in-place 4-5 rule pass over a streamed tile map
// throughput: one request per cycle while ready is high; the request that completes a
// neighborhood pushes its result into cas_rsp_buf, map_width+1 tiles behind its own tile
// ready is held low only while the output register and its skid entry are both full
// synchronous reset: counters clear, size returns to 64x64; ram contents are not cleared
// depends on cas_pkg, cas_if, cas_ram and cas_rsp_buf

module cave_automaton_smoothing import cas_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cas_req_if.sink   req_chan,
   cas_rsp_if.source rsp_chan,
   cas_csr_if.sink   csr_chan
);

   // configuration and counters
   logic [WDIM_W-1:0]  width_ff, width_in;
   logic [HDIM_W-1:0]  height_ff, height_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   rcvd_ff, rcvd_in;
   logic [CNT_W-1:0]   emit_ff, emit_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               held_ff, held_in;
   logic               prev_s_ff, prev_s_in;
   logic               last0_ff, last1_ff, last2_ff;
   logic               byp_top_ff, byp_tr_ff, byp_s_ff;

   logic               req_fire, csr_fire, restart;
   logic               store_tile, emit, done;
   logic [CNT_W-1:0]   rcvd_eff, lead_lim, gap, emit_inc;
   logic [CNT_W-1:0]   w_p0, w_p1, w_p2;
   logic               n0, n1, n2;
   logic [RING_AW-1:0] ring_addr_a, ring_addr_b;
   logic               ring_a, ring_b;
   logic [COL_W-1:0]   sr_addr_b;
   logic               sr_a, sr_b;
   logic               top_raw, tr_raw;
   logic               at_left, at_right, at_top, at_bottom;
   logic               nb_tl, nb_t, nb_tr, nb_l, nb_r, nb_bl, nb_b, nb_br;
   logic               centre;
   logic [3:0]         walls;
   logic               smoothed;
   logic               can_push;
   cas_result_type     result;
   logic [WDIM_W-1:0]  new_width;
   logic [HDIM_W-1:0]  new_height;

   // handshakes
   assign req_chan.ready = can_push;
   assign csr_chan.ready = 1'b1;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign restart  = csr_fire &&
                     (csr_chan.index == REG_MAP_WIDTH || csr_chan.index == REG_MAP_HEIGHT);

   // tile intake and emit decision
   assign store_tile = req_fire && (req_chan.req_type == REQ_TILE) && (rcvd_ff < total_ff);
   assign rcvd_eff   = store_tile ? rcvd_ff + CNT_W'(1) : rcvd_ff;
   assign lead_lim   = emit_ff + CNT_W'(width_ff) + CNT_W'(2);
   assign emit_inc   = emit_ff + CNT_W'(1);
   assign done       = (emit_inc >= total_ff);

   always_comb begin
      emit = 1'b0;
      if (req_fire) begin
         if (store_tile) begin
            emit = (rcvd_eff >= total_ff) || (rcvd_eff >= lead_lim);
         end else begin
            emit = (rcvd_ff >= total_ff) && (emit_ff < total_ff);
         end
      end
   end

   // the three most recent originals, with this request's tile shifted in
   assign n0 = store_tile ? req_chan.in_tile : last0_ff;
   assign n1 = store_tile ? last0_ff : last1_ff;
   assign n2 = store_tile ? last1_ff : last2_ff;

   // distance from the output tile to the tile after the newest one
   assign gap  = rcvd_eff - emit_ff;
   assign w_p0 = CNT_W'(width_ff);
   assign w_p1 = CNT_W'(width_ff) + CNT_W'(1);
   assign w_p2 = CNT_W'(width_ff) + CNT_W'(2);

   // map edges
   assign at_left   = (col_ff == '0);
   assign at_right  = (WDIM_W'(col_ff) == width_ff - WDIM_W'(1));
   assign at_top    = (row_ff == '0);
   assign at_bottom = (HDIM_W'(row_ff) == height_ff - HDIM_W'(1));

   // original tiles: centre, right and the row below
   always_comb begin
      if (gap == CNT_W'(1)) begin
         centre = n0;
      end else if (gap == CNT_W'(2)) begin
         centre = n1;
      end else if (gap == CNT_W'(3)) begin
         centre = n2;
      end else begin
         centre = ring_a;
      end

      if (gap == CNT_W'(2)) begin
         nb_r = n0;
      end else if (gap == CNT_W'(3)) begin
         nb_r = n1;
      end else if (gap == CNT_W'(4)) begin
         nb_r = n2;
      end else begin
         nb_r = ring_b;
      end

      nb_br = (gap == w_p2) ? n0 : 1'b0;

      if (gap == w_p2) begin
         nb_b = n1;
      end else if (gap == w_p1) begin
         nb_b = n0;
      end else begin
         nb_b = 1'b0;
      end

      if (gap == w_p2) begin
         nb_bl = n2;
      end else if (gap == w_p1) begin
         nb_bl = n1;
      end else if (gap == w_p0) begin
         nb_bl = n0;
      end else begin
         nb_bl = 1'b0;
      end
   end

   // smoothed tiles: row above from the row store, left from the last result
   assign top_raw = byp_top_ff ? byp_s_ff : sr_a;
   assign tr_raw  = byp_tr_ff ? byp_s_ff : sr_b;
   assign nb_tl   = held_ff;
   assign nb_t    = top_raw;
   assign nb_tr   = tr_raw;
   assign nb_l    = prev_s_ff;

   // wall count, out-of-map neighbours count as walls
   assign walls = 4'((at_left || at_top)      ? 1'b1 : nb_tl)
                + 4'(at_top                   ? 1'b1 : nb_t)
                + 4'((at_right || at_top)     ? 1'b1 : nb_tr)
                + 4'(at_left                  ? 1'b1 : nb_l)
                + 4'(at_right                 ? 1'b1 : nb_r)
                + 4'((at_left || at_bottom)   ? 1'b1 : nb_bl)
                + 4'(at_bottom                ? 1'b1 : nb_b)
                + 4'((at_right || at_bottom)  ? 1'b1 : nb_br);

   assign smoothed = apply_rule(walls, centre);

   assign result.smoothed_tile = smoothed;
   assign result.end_of_map    = done;

   // configuration values and map size
   assign new_width  = (csr_chan.index == REG_MAP_WIDTH) ? clamp_width(csr_chan.data) : width_ff;
   assign new_height = (csr_chan.index == REG_MAP_HEIGHT) ?
                       clamp_height(csr_chan.data) : height_ff;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      total_in  = total_ff;
      if (restart) begin
         width_in  = new_width;
         height_in = new_height;
         total_in  = CNT_W'(new_width) * CNT_W'(new_height);
      end
   end

   // position tracking
   always_comb begin
      rcvd_in   = rcvd_eff;
      emit_in   = emit_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      held_in   = held_ff;
      prev_s_in = prev_s_ff;
      if (restart) begin
         rcvd_in = '0;
         emit_in = '0;
         col_in  = '0;
         row_in  = '0;
         held_in = 1'b0;
      end else if (emit) begin
         held_in   = top_raw;
         prev_s_in = smoothed;
         if (done) begin
            rcvd_in = '0;
            emit_in = '0;
            col_in  = '0;
            row_in  = '0;
         end else begin
            emit_in = emit_inc;
            if (at_right) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         total_ff  <= CNT_W'(WIDTH_RESET) * CNT_W'(HEIGHT_RESET);
         rcvd_ff   <= '0;
         emit_ff   <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         held_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         total_ff  <= total_in;
         rcvd_ff   <= rcvd_in;
         emit_ff   <= emit_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         held_ff   <= held_in;
      end
   end

   // recent originals, last result and row store write bypass
   always_ff @(posedge clock) begin
      if (store_tile) begin
         last0_ff <= req_chan.in_tile;
         last1_ff <= last0_ff;
         last2_ff <= last1_ff;
      end
      prev_s_ff  <= prev_s_in;
      byp_top_ff <= emit && (col_ff == col_in);
      byp_tr_ff  <= emit && (col_ff == sr_addr_b);
      byp_s_ff   <= smoothed;
   end

   // original tile ring, read at the next output position and the one after
   assign ring_addr_a = emit_in[RING_AW-1:0];
   assign ring_addr_b = ring_addr_a + RING_AW'(1);

   cas_ram #(
      .DATA_W (1),
      .DEPTH  (RING_DEPTH)
   ) u_ring (
      .clock     (clock),
      .wr_en     (store_tile),
      .wr_addr   (rcvd_ff[RING_AW-1:0]),
      .wr_data   (req_chan.in_tile),
      .rd_addr_a (ring_addr_a),
      .rd_addr_b (ring_addr_b),
      .rd_data_a (ring_a),
      .rd_data_b (ring_b)
   );

   // smoothed row store, read at the next column and the column after
   assign sr_addr_b = (32'(col_in) == MAX_WIDTH - 1) ? '0 : col_in + COL_W'(1);

   cas_ram #(
      .DATA_W (1),
      .DEPTH  (MAX_WIDTH)
   ) u_row_store (
      .clock     (clock),
      .wr_en     (emit),
      .wr_addr   (col_ff),
      .wr_data   (smoothed),
      .rd_addr_a (col_in),
      .rd_addr_b (sr_addr_b),
      .rd_data_a (sr_a),
      .rd_data_b (sr_b)
   );

   // response output register
   cas_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (result),
      .can_push  (can_push),
      .rsp_chan  (rsp_chan)
   );

   // checks
   a_emit_behind_rcvd : assert property (@(posedge clock) disable iff (reset)
      emit_ff <= rcvd_ff)
      else $error("output position passed the intake position");

   a_gap_bounded : assert property (@(posedge clock) disable iff (reset)
      (rcvd_ff - emit_ff) <= w_p2)
      else $error("intake ran more than a row and two tiles ahead");

   a_position_in_map : assert property (@(posedge clock) disable iff (reset)
      (WDIM_W'(col_ff) < width_ff) && (HDIM_W'(row_ff) < height_ff))
      else $error("column or row outside the map");

   a_map_end_restarts : assert property (@(posedge clock) disable iff (reset)
      (emit && done) |=> (emit_ff == '0 && rcvd_ff == '0))
      else $error("counters not cleared after the final tile");

endmodule

@@ tb/cave_automaton_smoothing_tb.sv @@
// self-checking testbench for cave_automaton_smoothing: streams tile maps of many sizes
// under several stall patterns and checks each smoothed tile against an in-bench model
// depends on cas_pkg, the cas_*_if interfaces and the cave_automaton_smoothing rtl

module cave_automaton_smoothing_tb;
   import cas_pkg::*;

   // register indexes the block does not decode
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = CSR_IDX_W'(3);

   localparam int PHASE_COUNT  = 14;
   localparam int PHASE_BUDGET = 50;
   localparam int DRAIN_CYCLES = 4;

   // directed 4x3 map, first tile in the top bit, rows 1101 / 0100 / 1011
   localparam logic [11:0] DIRECTED_MAP = 12'b1101_0100_1011;

   typedef struct packed {
      logic kind;
      logic tile;
      logic hold;
   } tile_request_type;

   logic clock;
   logic reset;

   cas_req_if req_chan();
   cas_rsp_if rsp_chan();
   cas_csr_if csr_chan();

   cave_automaton_smoothing uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // map sizes per random phase, raw register values
   logic [SIZE_W-1:0] width_plan  [PHASE_COUNT] = '{5, 0, 1, 6, 128, 3, 1, 8, 2, 4, 11, 7, 2, 255};
   logic [SIZE_W-1:0] height_plan [PHASE_COUNT] = '{4, 0, 6, 1, 2, 3, 255, 6, 2, 9, 5, 3, 7, 1};

   tile_request_type pending_requests [$];
   cas_result_type   expected_tiles [$];

   int unsigned requests_queued   = 0;
   int unsigned requests_accepted = 0;
   int unsigned results_checked   = 0;
   int unsigned maps_checked      = 0;
   int unsigned settings_applied  = 0;
   int unsigned mismatch_count    = 0;
   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_stall_pct = 0;
   bit          req_taken = 1'b0;
   bit          csr_taken = 1'b0;

   // model state: size registers, smoothed rows, original tiles by map position
   logic [SIZE_W-1:0] width_setting  = SIZE_W'(64);
   logic [SIZE_W-1:0] height_setting = SIZE_W'(64);
   bit                row_store [MAX_WIDTH];
   bit                above_left = 1'b0;
   bit                tile_history [MAX_WIDTH*MAX_HEIGHT];
   int unsigned       received_count = 0;
   int unsigned       emitted_count  = 0;

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = ~clock;
   end

   function automatic int unsigned usable_size(logic [SIZE_W-1:0] raw, int unsigned limit);
      if (raw == '0) begin
         return 1;
      end
      if (int'(raw) > limit) begin
         return limit;
      end
      return 32'(raw);
   endfunction

   // smooth the next tile in raster order from the 3x3 window around it
   function automatic cas_result_type emit_smoothed(int unsigned w, int unsigned h);
      int unsigned    n, e, x, y, walls;
      bit             on_left, on_right, on_top, on_bottom, wall;
      cas_result_type res;
      n = w * h;
      e = emitted_count;
      x = e % w;
      y = e / w;
      on_left   = (x == 0);
      on_right  = (x + 1 >= w);
      on_top    = (y == 0);
      on_bottom = (y + 1 >= h);
      walls = 0;
      // above row and left neighbor are already smoothed
      walls += (on_left || on_top) ? 1 : above_left;
      walls += on_top ? 1 : row_store[x];
      walls += (on_right || on_top) ? 1 : row_store[(x + 1) % MAX_WIDTH];
      walls += on_left ? 1 : row_store[(x + MAX_WIDTH - 1) % MAX_WIDTH];
      // right neighbor and row below are original tiles
      walls += on_right ? 1 : tile_history[e + 1];
      walls += (on_left || on_bottom) ? 1 : tile_history[e + w - 1];
      walls += on_bottom ? 1 : tile_history[e + w];
      walls += (on_right || on_bottom) ? 1 : tile_history[e + w + 1];
      if (walls > RULE_LEVEL) begin
         wall = 1'b1;
      end else if (walls < RULE_LEVEL) begin
         wall = 1'b0;
      end else begin
         wall = tile_history[e];
      end
      above_left = row_store[x];
      row_store[x] = wall;
      res.smoothed_tile = wall;
      res.end_of_map = (e + 1 == n);
      emitted_count = e + 1;
      if (emitted_count >= n) begin
         emitted_count = 0;
         received_count = 0;
      end
      return res;
   endfunction

   // returns 1 when the request releases a smoothed tile
   function automatic bit smooth_request(logic kind, logic tile, output cas_result_type res);
      int unsigned w, h, n;
      w = usable_size(width_setting, MAX_WIDTH);
      h = usable_size(height_setting, MAX_HEIGHT);
      n = w * h;
      res = '0;
      if (kind == REQ_TILE && received_count < n) begin
         tile_history[received_count] = tile;
         received_count++;
         if (received_count >= n || received_count >= emitted_count + w + 2) begin
            res = emit_smoothed(w, h);
            return 1'b1;
         end
         return 1'b0;
      end
      // flush, or a tile past the end of the map
      if (received_count >= n && emitted_count < n) begin
         res = emit_smoothed(w, h);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic queue_request(logic kind, logic tile, logic hold);
      tile_request_type item;
      item.kind = kind;
      item.tile = tile;
      item.hold = hold;
      pending_requests.insert(pending_requests.size(), item);
      requests_queued++;
   endtask

   // one map in raster order with stray early flushes, then the drain unless the map is cut short
   task automatic queue_map(int unsigned w, int unsigned h, bit broken, bit pause_first);
      int unsigned n, tiles, wall_pct, drain;
      n = w * h;
      tiles = (broken && n > 1) ? $urandom_range(n - 1, 1) : n;
      wall_pct = $urandom_range(85, 15);
      for (int unsigned k = 0; k < tiles; k++) begin
         queue_request(REQ_TILE, $urandom_range(99) < wall_pct, pause_first && k == 0);
         if (k + 1 < n && $urandom_range(11) == 0) begin
            queue_request(REQ_FLUSH, $urandom_range(1), 1'b0);
         end
      end
      if (!broken) begin
         drain = (n - 1 < w + 1) ? n - 1 : w + 1;
         repeat (drain) begin
            if ($urandom_range(9) < 7) begin
               queue_request(REQ_FLUSH, $urandom_range(1), 1'b0);
            end else begin
               queue_request(REQ_TILE, $urandom_range(1), 1'b0);
            end
         end
         if ($urandom_range(3) == 0) begin
            queue_request(REQ_FLUSH, $urandom_range(1), 1'b0);
         end
      end
   endtask

   // leaves csr valid high so back-to-back writes leave no gap on the channel
   task automatic write_setting(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(negedge clock);
      while (!csr_taken) begin
         @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      while (requests_accepted != requests_queued || expected_tiles.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // request driver, fed from the pending queue
   always @(negedge clock) begin : request_driver
      tile_request_type next_req;
      if (reset) begin
         req_chan.valid    <= 1'b0;
         req_chan.req_type <= REQ_FLUSH;
         req_chan.in_tile  <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
             !(pending_requests[0].hold && expected_tiles.size() != 0)) begin
            next_req = pending_requests.pop_front();
            req_chan.valid    <= 1'b1;
            req_chan.req_type <= next_req.kind;
            req_chan.in_tile  <= next_req.tile;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // monitor: config writes, request prediction, result checking
   always @(posedge clock) begin : monitor
      cas_result_type predicted;
      cas_result_type oldest;
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.index == REG_MAP_WIDTH || csr_chan.index == REG_MAP_HEIGHT) begin
               if (csr_chan.index == REG_MAP_WIDTH) begin
                  width_setting = csr_chan.data;
               end else begin
                  height_setting = csr_chan.data;
               end
               // a size write restarts the map
               received_count = 0;
               emitted_count = 0;
               above_left = 1'b0;
               settings_applied++;
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            requests_accepted++;
            if (smooth_request(req_chan.req_type, req_chan.in_tile, predicted)) begin
               expected_tiles.insert(expected_tiles.size(), predicted);
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_checked++;
            if (expected_tiles.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with none expected, smoothed_tile %0b end_of_map %0b",
                        $time, rsp_chan.smoothed_tile, rsp_chan.end_of_map);
            end else begin
               oldest = expected_tiles.pop_front();
               if (rsp_chan.smoothed_tile !== oldest.smoothed_tile) begin
                  mismatch_count++;
                  $display("%0t: smoothed_tile expected %0b actual %0b", $time,
                           oldest.smoothed_tile, rsp_chan.smoothed_tile);
               end
               if (rsp_chan.end_of_map !== oldest.end_of_map) begin
                  mismatch_count++;
                  $display("%0t: end_of_map expected %0b actual %0b", $time,
                           oldest.end_of_map, rsp_chan.end_of_map);
               end
               if (oldest.end_of_map) begin
                  maps_checked++;
               end
            end
         end
      end
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      csr_taken <= !reset && csr_chan.valid && csr_chan.ready;
   end

   // stimulus
   initial begin : stimulus
      int unsigned w, h, start;
      reset = 1'b1;
      csr_chan.valid    = 1'b0;
      csr_chan.index    = REG_MAP_WIDTH;
      csr_chan.data     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: early flush, a 4x3 map hitting edges and corners, a tile past the end
      write_setting(REG_MAP_WIDTH, SIZE_W'(4));
      write_setting(REG_MAP_HEIGHT, SIZE_W'(3));
      csr_chan.valid <= 1'b0;
      queue_request(REQ_FLUSH, 1'b1, 1'b0);
      for (int k = 0; k < 12; k++) begin
         queue_request(REQ_TILE, DIRECTED_MAP[11 - k], k == 0);
      end
      queue_request(REQ_FLUSH, 1'b0, 1'b0);
      queue_request(REQ_TILE, 1'b1, 1'b0);
      queue_request(REQ_FLUSH, 1'b1, 1'b0);
      queue_request(REQ_FLUSH, 1'b0, 1'b0);
      queue_request(REQ_FLUSH, 1'b0, 1'b0);
      queue_request(REQ_FLUSH, 1'b1, 1'b0);
      wait_drained();

      // random maps, one size setting and stall pattern per phase
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_setting(REG_MAP_WIDTH, width_plan[p]);
         write_setting(REG_MAP_HEIGHT, height_plan[p]);
         if (p % 3 == 0) begin
            write_setting((p % 2 == 1) ? REG_SPARE_A : REG_SPARE_B, SIZE_W'($urandom_range(255)));
         end
         csr_chan.valid <= 1'b0;
         case (p % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 63;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 63;
            end
            default: begin
               sender_idle_pct = 24;
               receiver_stall_pct = 24;
            end
         endcase
         w = usable_size(width_plan[p], MAX_WIDTH);
         h = usable_size(height_plan[p], MAX_HEIGHT);
         start = requests_queued;
         queue_map(w, h, 1'b0, 1'b1);
         while (requests_queued - start < PHASE_BUDGET) begin
            queue_map(w, h, 1'b0, $urandom_range(7) == 0);
         end
         // cut the last map short now and then; the next size write restarts it
         if (w * h <= 64 && $urandom_range(1) == 1) begin
            queue_map(w, h, 1'b1, 1'b0);
         end
         wait_drained();
      end

      repeat (8) @(negedge clock);
      $display("%0d requests accepted over %0d size settings and four stall patterns",
               requests_accepted, settings_applied);
      $display("%0d smoothed tiles checked, %0d complete maps", results_checked, maps_checked);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
design/cas_pkg.sv
design/cas_if.sv
design/cas_ram.sv
design/cas_rsp_buf.sv
design/cave_automaton_smoothing.sv
tb/cave_automaton_smoothing_tb.sv
